// ----- rtl/core/tbpc_pkg.sv -----
// ----------------------------------------------------------------------------
// tbpc_pkg
// types and fixed widths shared by the timed blind position controller
// ----------------------------------------------------------------------------
`default_nettype none

package tbpc_pkg;

   // fixed field widths
   localparam int TIME_W     = 32;
   localparam int TRAVEL_W   = 20;
   localparam int OFFSET_W   = 16;
   localparam int OVERRUN_W  = 20;
   localparam int INTERVAL_W = 16;
   localparam int POS_PORT_W = 16;
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 20;

   // register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_TRAVEL_UP   = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_TRAVEL_DOWN = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_OFFSET_UP   = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_OFFSET_DOWN = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_OVERRUN     = 3'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_INTERVAL    = 3'd5;

   // register reset values
   localparam logic [TRAVEL_W-1:0]   TRAVEL_RESET   = 20'd30000;
   localparam logic [INTERVAL_W-1:0] INTERVAL_RESET = 16'd500;

   typedef enum logic [1:0] {
      OP_TICK   = 2'd0,
      OP_STOP   = 2'd1,
      OP_TOGGLE = 2'd2,
      OP_SET    = 2'd3
   } opcode_type;

   typedef enum logic [1:0] {
      MODE_IDLE = 2'd0,
      MODE_UP   = 2'd1,
      MODE_DOWN = 2'd2,
      MODE_END  = 2'd3
   } mode_type;

   typedef enum logic [1:0] {
      OPER_IDLE    = 2'd0,
      OPER_OPENING = 2'd1,
      OPER_CLOSING = 2'd2
   } oper_type;

   typedef enum logic [2:0] {
      S_IDLE = 3'd0,
      S_PREP = 3'd1,
      S_LOAD = 3'd2,
      S_MUL  = 3'd3,
      S_DIV  = 3'd4,
      S_EST  = 3'd5,
      S_EXEC = 3'd6,
      S_POST = 3'd7
   } state_type;

endpackage : tbpc_pkg

`default_nettype wire

// ----- rtl/core/timed_blind_position_controller.sv -----
// ----------------------------------------------------------------------------
// timed_blind_position_controller
// time based blind position estimate and up/down relay control
// ----------------------------------------------------------------------------
// steps from accepted beat to result beat: prep, load, then mul, the divider and
//   est while the blind travels past its dead offset, then exec and post
// no new beat is taken until the previous one has reached post; the divider is
//   a bit-serial restoring divider that steps once per dividend bit
// a new beat is taken while the previous result still waits in the output
// reset (synchronous): position closed, idle, registers to their defaults
`default_nettype none

module timed_blind_position_controller
   import tbpc_pkg::*;
#(
   parameter int POSITION_BITS = 16
) (
   input  wire                         clock,
   input  wire                         reset,
   // configuration writes
   input  wire                         csr_write_en,
   input  wire  [CSR_IDX_W-1:0]        csr_index,
   input  wire  [CSR_DATA_W-1:0]       csr_write_data,
   // command beats
   input  wire                         req_valid,
   output logic                        req_stall,
   input  wire  [1:0]                  req_opcode,
   input  wire  [TIME_W-1:0]           req_time_ms,
   input  wire  [POS_PORT_W-1:0]       req_target_position,
   // result beats
   output logic                        rsp_valid,
   input  wire                         rsp_stall,
   output logic                        rsp_drive_up,
   output logic                        rsp_drive_down,
   output logic [POS_PORT_W-1:0]       rsp_position,
   output logic [1:0]                  rsp_operation,
   output logic                        rsp_report
);

   localparam int P         = POSITION_BITS;
   localparam int NUM_W     = TIME_W + P;       // dividend: elapsed * full scale
   localparam int DIV_STEPS = NUM_W;            // one quotient bit per cycle
   localparam int CNT_W     = $clog2(DIV_STEPS);
   localparam logic [P-1:0] FULL_POS = {P{1'b1}};
   localparam logic [P-1:0] MID_POS  = {1'b1, {(P-1){1'b0}}};

   // ---------------------------------------------------------------------------
   // configuration registers
   // ---------------------------------------------------------------------------
   logic [TRAVEL_W-1:0]   travel_up_ff, travel_down_ff;
   logic [OFFSET_W-1:0]   offset_up_ff, offset_down_ff;
   logic [OVERRUN_W-1:0]  overrun_ff;
   logic [INTERVAL_W-1:0] interval_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         travel_up_ff   <= TRAVEL_RESET;
         travel_down_ff <= TRAVEL_RESET;
         offset_up_ff   <= '0;
         offset_down_ff <= '0;
         overrun_ff     <= '0;
         interval_ff    <= INTERVAL_RESET;
      end else if (csr_write_en) begin
         case (csr_index)
            CSR_TRAVEL_UP:   travel_up_ff   <= csr_write_data;
            CSR_TRAVEL_DOWN: travel_down_ff <= csr_write_data;
            CSR_OFFSET_UP:   offset_up_ff   <= csr_write_data[OFFSET_W-1:0];
            CSR_OFFSET_DOWN: offset_down_ff <= csr_write_data[OFFSET_W-1:0];
            CSR_OVERRUN:     overrun_ff     <= csr_write_data;
            CSR_INTERVAL:    interval_ff    <= csr_write_data[INTERVAL_W-1:0];
            default: ;       // indexes past the list are dropped
         endcase
      end
   end

   // ---------------------------------------------------------------------------
   // sequencer
   // ---------------------------------------------------------------------------
   state_type state_ff, state_in;
   logic      go_div;            // travelling and past the dead offset
   logic      slot_free;         // output register empty or emptying now
   logic      rsp_valid_ff;      // output register holds a result beat
   logic [CNT_W-1:0] cnt_ff, cnt_in;

   assign slot_free = !rsp_valid_ff || !rsp_stall;

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         S_IDLE: if (req_valid) state_in = S_PREP;
         S_PREP: state_in = S_LOAD;
         S_LOAD: state_in = go_div ? S_MUL : S_EXEC;
         S_MUL:  state_in = S_DIV;
         S_DIV:  if (cnt_ff == '0) state_in = S_EST;
         S_EST:  state_in = S_EXEC;
         S_EXEC: state_in = S_POST;
         S_POST: if (slot_free) state_in = S_IDLE;
         default: state_in = S_IDLE;
      endcase
   end

   logic do_capture, do_prep, do_load, do_mul, do_div, do_est, do_exec, do_post;

   always_comb begin
      req_stall  = 1'b1;
      do_capture = 1'b0;
      do_prep    = 1'b0;
      do_load    = 1'b0;
      do_mul     = 1'b0;
      do_div     = 1'b0;
      do_est     = 1'b0;
      do_exec    = 1'b0;
      do_post    = 1'b0;
      case (state_ff)
         S_IDLE: begin
            req_stall  = 1'b0;
            do_capture = req_valid;
         end
         S_PREP: do_prep = 1'b1;
         S_LOAD: do_load = 1'b1;
         S_MUL:  do_mul  = 1'b1;
         S_DIV:  do_div  = 1'b1;
         S_EST:  do_est  = 1'b1;
         S_EXEC: do_exec = 1'b1;
         S_POST: do_post = slot_free;
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // ---------------------------------------------------------------------------
   // captured beat
   // ---------------------------------------------------------------------------
   opcode_type        op_ff;
   logic [TIME_W-1:0] now_ff;
   logic [P-1:0]      tgt_ff;

   always_ff @(posedge clock) begin
      if (do_capture) begin
         op_ff  <= opcode_type'(req_opcode);
         now_ff <= req_time_ms;
         tgt_ff <= P'(req_target_position);   // masked or widened to the position width
      end
   end

   // ---------------------------------------------------------------------------
   // motion state
   // ---------------------------------------------------------------------------
   mode_type          mode_ff, mode_in;
   oper_type          oper_ff, oper_in;
   logic [P-1:0]      cur_ff, cur_in;
   logic [P-1:0]      goal_ff, goal_in;
   logic [P-1:0]      spos_ff, spos_in;
   logic [TIME_W-1:0] stime_ff, stime_in;
   logic [TIME_W-1:0] lrep_ff, lrep_in;
   logic              report_ff, report_in;
   logic              moving;

   assign moving = (mode_ff == MODE_UP) || (mode_ff == MODE_DOWN);

   // ---------------------------------------------------------------------------
   // timing front end: elapsed time, report gap, dead offset, dividend
   // ---------------------------------------------------------------------------
   logic [TIME_W-1:0]   elapsed_ff;
   logic                rep_due_ff;
   logic                end_done_ff;
   logic [TIME_W-1:0]   x_ff;
   logic [TRAVEL_W-1:0] full_ff;
   logic [OFFSET_W-1:0] off_sel;
   logic [TRAVEL_W-1:0] full_sel;
   logic [TIME_W-1:0]   rep_gap;

   assign rep_gap  = now_ff - lrep_ff;
   assign off_sel  = (mode_ff == MODE_UP) ? offset_up_ff : offset_down_ff;
   assign full_sel = (mode_ff == MODE_UP) ? travel_up_ff : travel_down_ff;
   assign go_div   = moving && (elapsed_ff >= TIME_W'(off_sel));

   always_ff @(posedge clock) begin
      if (do_prep) begin
         elapsed_ff <= now_ff - stime_ff;
         rep_due_ff <= rep_gap > TIME_W'(interval_ff);
      end
      if (do_load) begin
         end_done_ff <= elapsed_ff >= TIME_W'(overrun_ff);
         x_ff        <= elapsed_ff - TIME_W'(off_sel);
         // a zero travel time counts as one millisecond
         full_ff     <= (full_sel == '0) ? TRAVEL_W'(1) : full_sel;
      end
   end

   // ---------------------------------------------------------------------------
   // bit-serial restoring divider: (x * FULL) / travel, saturating at FULL
   // ---------------------------------------------------------------------------
   logic [NUM_W-1:0]    num_ff;
   logic [TRAVEL_W-1:0] rem_ff;
   logic [P-1:0]        quo_ff;
   logic                sat_ff;
   logic [TRAVEL_W:0]   trial;
   logic                trial_ge;

   assign trial    = {rem_ff, num_ff[NUM_W-1]};
   assign trial_ge = trial >= {1'b0, full_ff};
   assign cnt_in   = (state_ff == S_MUL) ? CNT_W'(DIV_STEPS - 1) : cnt_ff - 1'b1;

   always_ff @(posedge clock) begin
      if (do_mul) begin
         // x * (2^P - 1) as a shift and a subtract
         num_ff <= {x_ff, {P{1'b0}}} - NUM_W'(x_ff);
         rem_ff <= '0;
         sat_ff <= 1'b0;
         quo_ff <= '0;
      end else if (do_div) begin
         num_ff <= {num_ff[NUM_W-2:0], 1'b0};
         rem_ff <= trial_ge ? TRAVEL_W'(trial - {1'b0, full_ff}) : trial[TRAVEL_W-1:0];
         quo_ff <= {quo_ff[P-2:0], trial_ge};
         sat_ff <= sat_ff | quo_ff[P-1];   // quotient bit above full scale
      end
      if (do_mul || do_div) begin
         cnt_ff <= cnt_in;
      end
   end

   // ---------------------------------------------------------------------------
   // position estimate
   // ---------------------------------------------------------------------------
   logic [P-1:0] est_ff;
   logic [P-1:0] delta;
   logic [P:0]   up_sum;

   assign delta  = sat_ff ? FULL_POS : quo_ff;
   assign up_sum = {1'b0, spos_ff} + {1'b0, delta};

   always_ff @(posedge clock) begin
      if (do_load) begin
         est_ff <= cur_ff;   // held while idle or inside the dead offset
      end else if (do_est) begin
         if (mode_ff == MODE_UP) begin
            est_ff <= up_sum[P] ? FULL_POS : up_sum[P-1:0];
         end else begin
            est_ff <= (spos_ff >= delta) ? spos_ff - delta : '0;
         end
      end
   end

   // ---------------------------------------------------------------------------
   // command execution
   // ---------------------------------------------------------------------------
   logic         do_halt, do_retarget, reached;
   logic [P-1:0] new_tgt;
   mode_type     new_dir;

   always_comb begin
      mode_in     = mode_ff;
      oper_in     = oper_ff;
      cur_in      = cur_ff;
      goal_in     = goal_ff;
      spos_in     = spos_ff;
      stime_in    = stime_ff;
      lrep_in     = lrep_ff;
      report_in   = 1'b0;
      do_halt     = 1'b0;
      do_retarget = 1'b0;
      // toggle from rest heads to the far end from the midpoint
      new_tgt     = (op_ff == OP_TOGGLE) ? ((cur_ff >= MID_POS) ? '0 : FULL_POS) : tgt_ff;
      new_dir     = (new_tgt >= cur_ff) ? MODE_UP : MODE_DOWN;
      reached     = (mode_ff == MODE_UP) ? (est_ff >= goal_ff) : (est_ff <= goal_ff);

      case (op_ff)
         OP_TICK: begin
            if (moving) begin
               if (reached) begin
                  cur_in    = goal_ff;
                  oper_in   = OPER_IDLE;
                  report_in = 1'b1;
                  if ((goal_ff == '0 || goal_ff == FULL_POS) && overrun_ff != '0) begin
                     mode_in  = MODE_END;
                     stime_in = now_ff;
                  end else begin
                     mode_in = MODE_IDLE;
                  end
               end else begin
                  cur_in = est_ff;
                  if (rep_due_ff) begin
                     report_in = 1'b1;
                     lrep_in   = now_ff;
                  end
               end
            end else if (mode_ff == MODE_END && end_done_ff) begin
               mode_in = MODE_IDLE;
            end
         end
         OP_STOP: begin
            do_halt   = 1'b1;
            report_in = 1'b1;
         end
         OP_TOGGLE: begin
            do_retarget = (mode_ff == MODE_IDLE);
            do_halt     = (mode_ff != MODE_IDLE);
            report_in   = 1'b1;
         end
         OP_SET: begin
            do_retarget = 1'b1;
            report_in   = 1'b1;
         end
         default: ;
      endcase

      // a target equal to the stored position is a stop
      if (do_retarget && new_tgt == cur_ff) begin
         do_halt     = 1'b1;
         do_retarget = 1'b0;
      end
      if (do_halt) begin
         cur_in  = est_ff;
         mode_in = MODE_IDLE;
         oper_in = OPER_IDLE;
      end
      if (do_retarget) begin
         if (new_dir != mode_ff) begin
            mode_in  = new_dir;
            oper_in  = (new_dir == MODE_UP) ? OPER_OPENING : OPER_CLOSING;
            stime_in = now_ff;
            lrep_in  = now_ff;
            spos_in  = cur_ff;
         end
         goal_in = new_tgt;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff  <= MODE_IDLE;
         oper_ff  <= OPER_IDLE;
         cur_ff   <= '0;
         goal_ff  <= '0;
         spos_ff  <= '0;
         stime_ff <= '0;
         lrep_ff  <= '0;
      end else if (do_exec) begin
         mode_ff  <= mode_in;
         oper_ff  <= oper_in;
         cur_ff   <= cur_in;
         goal_ff  <= goal_in;
         spos_ff  <= spos_in;
         stime_ff <= stime_in;
         lrep_ff  <= lrep_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_exec) begin
         report_ff <= report_in;
      end
   end

   // ---------------------------------------------------------------------------
   // output register: holds the result beat, frees the engine
   // ---------------------------------------------------------------------------
   logic                  rsp_up_ff, rsp_down_ff, rsp_report_ff;
   logic [POS_PORT_W-1:0] rsp_pos_ff;
   logic [1:0]            rsp_oper_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (do_post) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (do_post) begin
         // at the endstop the relay of the reached end stays on
         rsp_up_ff     <= (mode_ff == MODE_UP) || (mode_ff == MODE_END && cur_ff == FULL_POS);
         rsp_down_ff   <= (mode_ff == MODE_DOWN) || (mode_ff == MODE_END && cur_ff != FULL_POS);
         rsp_pos_ff    <= POS_PORT_W'(cur_ff);
         rsp_oper_ff   <= oper_ff;
         rsp_report_ff <= report_ff;
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_drive_up   = rsp_up_ff;
   assign rsp_drive_down = rsp_down_ff;
   assign rsp_position   = rsp_pos_ff;
   assign rsp_operation  = rsp_oper_ff;
   assign rsp_report     = rsp_report_ff;

`ifndef NO_ASSERTIONS
   a_relays_exclusive: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !(rsp_drive_up && rsp_drive_down))
      else $error("both relays driven");

   a_opening_drives_up: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_operation == OPER_OPENING) |-> (rsp_drive_up && !rsp_drive_down))
      else $error("opening without up relay");

   a_rem_below_divisor: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_DIV) |-> (rem_ff < full_ff))
      else $error("divider remainder not below divisor");

   a_endstop_at_end: assert property (@(posedge clock) disable iff (reset)
      (mode_ff == MODE_END) |-> (cur_ff == '0 || cur_ff == FULL_POS))
      else $error("endstop overrun away from an end");
`endif

endmodule : timed_blind_position_controller

`default_nettype wire

// ----- verif/tbpc_result_check.sv -----
// ----------------------------------------------------------------------------
// tbpc_result_check
// watches the timed blind position controller, predicts and compares results
// ----------------------------------------------------------------------------
// keeps its own copy of the registers and of the blind's motion state, works
// out the relay levels, position, operation and report flag of every accepted
// command beat and compares each result beat with the oldest one still due
// ----------------------------------------------------------------------------

module tbpc_result_check
   import tbpc_pkg::*;
(
   input  wire                   clock,
   input  wire                   reset,
   input  wire                   csr_write_en,
   input  wire [CSR_IDX_W-1:0]   csr_index,
   input  wire [CSR_DATA_W-1:0]  csr_write_data,
   input  wire                   req_valid,
   input  wire                   req_stall,
   input  wire [1:0]             req_opcode,
   input  wire [TIME_W-1:0]      req_time_ms,
   input  wire [POS_PORT_W-1:0]  req_target_position,
   input  wire                   rsp_valid,
   input  wire                   rsp_stall,
   input  wire                   rsp_drive_up,
   input  wire                   rsp_drive_down,
   input  wire [POS_PORT_W-1:0]  rsp_position,
   input  wire [1:0]             rsp_operation,
   input  wire                   rsp_report,
   output int                    mismatch_count,
   output int                    outstanding
);
   timeunit 1ns;
   timeprecision 1ps;

   typedef logic [POS_PORT_W-1:0] pos_type;
   typedef logic [TIME_W-1:0]     ms_type;

   localparam pos_type     FULL_POS  = '1;
   localparam pos_type     MID_POS   = {1'b1, {(POS_PORT_W-1){1'b0}}};
   localparam logic [63:0] FULL_WIDE = 64'(FULL_POS);

   typedef struct packed {
      logic       drive_up;
      logic       drive_down;
      pos_type    position;
      logic [1:0] operation;
      logic       report;
   } relay_state_type;

   // register copies
   logic [TRAVEL_W-1:0]   travel_up, travel_down;
   logic [OFFSET_W-1:0]   lag_up, lag_down;
   logic [OVERRUN_W-1:0]  overrun;
   logic [INTERVAL_W-1:0] interval;

   // motion state
   mode_type blind_mode;
   oper_type oper;
   pos_type  cur_pos, goal_pos, start_pos;
   ms_type   start_time, last_report;

   relay_state_type due_states[$];

   function automatic void clear_blind();
      travel_up   = TRAVEL_RESET;
      travel_down = TRAVEL_RESET;
      lag_up      = '0;
      lag_down    = '0;
      overrun     = '0;
      interval    = INTERVAL_RESET;
      blind_mode  = MODE_IDLE;
      oper        = OPER_IDLE;
      cur_pos     = '0;
      goal_pos    = '0;
      start_pos   = '0;
      start_time  = '0;
      last_report = '0;
   endfunction

   // position from travel time, held inside the dead offset
   function automatic pos_type estimate_position(ms_type now);
      logic        rising;
      ms_type      elapsed, lag, span;
      logic [63:0] delta, total;
      if (blind_mode != MODE_UP && blind_mode != MODE_DOWN)
         return cur_pos;
      rising  = (blind_mode == MODE_UP);
      elapsed = now - start_time;
      lag     = rising ? ms_type'(lag_up) : ms_type'(lag_down);
      span    = rising ? ms_type'(travel_up) : ms_type'(travel_down);
      if (span == 0)
         span = 1;
      if (elapsed < lag)
         return cur_pos;
      elapsed = elapsed - lag;
      delta   = (64'(elapsed) * FULL_WIDE) / 64'(span);
      if (delta > FULL_WIDE)
         delta = FULL_WIDE;
      if (rising) begin
         total = 64'(start_pos) + delta;
         return (total > FULL_WIDE) ? FULL_POS : total[POS_PORT_W-1:0];
      end
      return (64'(start_pos) >= delta) ? start_pos - delta[POS_PORT_W-1:0] : '0;
   endfunction

   function automatic void halt_motion(ms_type now);
      cur_pos    = estimate_position(now);
      blind_mode = MODE_IDLE;
      oper       = OPER_IDLE;
   endfunction

   // new goal: restart only on a change of direction
   function automatic void aim_at(pos_type target, ms_type now);
      mode_type dir;
      if (cur_pos == target) begin
         halt_motion(now);
      end else begin
         dir = (target >= cur_pos) ? MODE_UP : MODE_DOWN;
         if (dir != blind_mode) begin
            blind_mode  = dir;
            oper        = (dir == MODE_UP) ? OPER_OPENING : OPER_CLOSING;
            start_time  = now;
            last_report = now;
            start_pos   = cur_pos;
         end
         goal_pos = target;
      end
   endfunction

   function automatic relay_state_type step_blind(opcode_type op, ms_type now,
                                                  pos_type target);
      relay_state_type res;
      logic            reached;
      res = '0;
      case (op)
         OP_TICK: begin
            if (blind_mode == MODE_UP || blind_mode == MODE_DOWN) begin
               cur_pos = estimate_position(now);
               reached = (blind_mode == MODE_UP) ? (cur_pos >= goal_pos)
                                                 : (cur_pos <= goal_pos);
               if (reached) begin
                  cur_pos = goal_pos;
                  oper    = OPER_IDLE;
                  if ((cur_pos == '0 || cur_pos == FULL_POS) && overrun != 0) begin
                     blind_mode = MODE_END;
                     start_time = now;
                  end else begin
                     blind_mode = MODE_IDLE;
                  end
                  res.report = 1'b1;
               end else if (now - last_report > ms_type'(interval)) begin
                  res.report  = 1'b1;
                  last_report = now;
               end
            end else if (blind_mode == MODE_END) begin
               if (now - start_time >= ms_type'(overrun))
                  blind_mode = MODE_IDLE;
            end
         end
         OP_STOP: begin
            halt_motion(now);
            res.report = 1'b1;
         end
         OP_TOGGLE: begin
            if (blind_mode == MODE_IDLE)
               aim_at((cur_pos >= MID_POS) ? pos_type'(0) : FULL_POS, now);
            else
               halt_motion(now);
            res.report = 1'b1;
         end
         default: begin
            aim_at(target, now);
            res.report = 1'b1;
         end
      endcase
      case (blind_mode)
         MODE_UP:   res.drive_up = 1'b1;
         MODE_DOWN: res.drive_down = 1'b1;
         MODE_END: begin
            if (cur_pos == FULL_POS)
               res.drive_up = 1'b1;
            else
               res.drive_down = 1'b1;
         end
         default: ;
      endcase
      res.position  = cur_pos;
      res.operation = oper;
      return res;
   endfunction

   always @(posedge clock) begin
      relay_state_type got, want;
      if (reset) begin
         clear_blind();
         due_states.delete();
         mismatch_count = 0;
      end else begin
         if (csr_write_en) begin
            case (csr_index)
               CSR_TRAVEL_UP:   travel_up   = csr_write_data[TRAVEL_W-1:0];
               CSR_TRAVEL_DOWN: travel_down = csr_write_data[TRAVEL_W-1:0];
               CSR_OFFSET_UP:   lag_up      = csr_write_data[OFFSET_W-1:0];
               CSR_OFFSET_DOWN: lag_down    = csr_write_data[OFFSET_W-1:0];
               CSR_OVERRUN:     overrun     = csr_write_data[OVERRUN_W-1:0];
               CSR_INTERVAL:    interval    = csr_write_data[INTERVAL_W-1:0];
               default: ;
            endcase
         end
         if (req_valid && !req_stall)
            due_states.push_back(step_blind(opcode_type'(req_opcode), req_time_ms,
                                            req_target_position));
         if (rsp_valid && !rsp_stall) begin
            got = {rsp_drive_up, rsp_drive_down, rsp_position, rsp_operation, rsp_report};
            if (due_states.size() == 0) begin
               if (mismatch_count < 10)
                  $display({"%0t: result beat with nothing due: ",
                            "up %b down %b pos %h op %0d rep %b"},
                           $time, got.drive_up, got.drive_down, got.position,
                           got.operation, got.report);
               mismatch_count++;
            end else begin
               want = due_states.pop_front();
               if (got !== want) begin
                  if (mismatch_count < 10)
                     $display({"%0t: mismatch: exp up %b down %b pos %h op %0d rep %b, ",
                               "got up %b down %b pos %h op %0d rep %b"},
                              $time, want.drive_up, want.drive_down, want.position,
                              want.operation, want.report, got.drive_up, got.drive_down,
                              got.position, got.operation, got.report);
                  mismatch_count++;
               end
            end
         end
      end
      outstanding <= due_states.size();
   end

endmodule : tbpc_result_check

// ----- verif/tb_top.sv -----
// ----------------------------------------------------------------------------
// tb_top
// regression bench for the timed blind position controller
// ----------------------------------------------------------------------------
// sends directed command sequences (dead offset, endstop overrun, toggle,
// time wrap) and then random tick-heavy traffic over several register
// settings incl. the extremes and a zero travel time; the result checker
// beside the block predicts every result beat and counts mismatches
// ----------------------------------------------------------------------------

module tb_top;
   import tbpc_pkg::*;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int HOLD_CYCLES = 400;  // long receiver hold-off
   localparam int TAIL_CYCLES = 60;   // a little over the worst block latency

   typedef struct {
      logic [TRAVEL_W-1:0]   travel_up;
      logic [TRAVEL_W-1:0]   travel_down;
      logic [OFFSET_W-1:0]   lag_up;
      logic [OFFSET_W-1:0]   lag_down;
      logic [OVERRUN_W-1:0]  overrun;
      logic [INTERVAL_W-1:0] interval;
   } blind_settings_type;

   logic                   clock;
   logic                   reset;
   logic                   csr_write_en;
   logic [CSR_IDX_W-1:0]   csr_index;
   logic [CSR_DATA_W-1:0]  csr_write_data;
   logic                   req_valid;
   logic                   req_stall;
   logic [1:0]             req_opcode;
   logic [TIME_W-1:0]      req_time_ms;
   logic [POS_PORT_W-1:0]  req_target_position;
   logic                   rsp_valid;
   logic                   rsp_stall;
   logic                   rsp_drive_up;
   logic                   rsp_drive_down;
   logic [POS_PORT_W-1:0]  rsp_position;
   logic [1:0]             rsp_operation;
   logic                   rsp_report;

   int mismatch_count;
   int outstanding;

   // stimulus bookkeeping
   blind_settings_type active;
   logic [TIME_W-1:0] now_ms;
   bit  calm;            // last part of the run: no idling on either side
   bit  hold_request;    // asks the receiver for one long hold-off
   bit  hold_done;       // the receiver has served the hold-off
   int  beats_sent;
   int  settings_used;

   timed_blind_position_controller i_dut (
      .clock               (clock),
      .reset               (reset),
      .csr_write_en        (csr_write_en),
      .csr_index           (csr_index),
      .csr_write_data      (csr_write_data),
      .req_valid           (req_valid),
      .req_stall           (req_stall),
      .req_opcode          (req_opcode),
      .req_time_ms         (req_time_ms),
      .req_target_position (req_target_position),
      .rsp_valid           (rsp_valid),
      .rsp_stall           (rsp_stall),
      .rsp_drive_up        (rsp_drive_up),
      .rsp_drive_down      (rsp_drive_down),
      .rsp_position        (rsp_position),
      .rsp_operation       (rsp_operation),
      .rsp_report          (rsp_report)
   );

   tbpc_result_check i_result_check (
      .clock               (clock),
      .reset               (reset),
      .csr_write_en        (csr_write_en),
      .csr_index           (csr_index),
      .csr_write_data      (csr_write_data),
      .req_valid           (req_valid),
      .req_stall           (req_stall),
      .req_opcode          (req_opcode),
      .req_time_ms         (req_time_ms),
      .req_target_position (req_target_position),
      .rsp_valid           (rsp_valid),
      .rsp_stall           (rsp_stall),
      .rsp_drive_up        (rsp_drive_up),
      .rsp_drive_down      (rsp_drive_down),
      .rsp_position        (rsp_position),
      .rsp_operation       (rsp_operation),
      .rsp_report          (rsp_report),
      .mismatch_count      (mismatch_count),
      .outstanding         (outstanding)
   );

   // 8 ns clock
   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   // hard stop well beyond the slowest legal run
   initial begin
      #3_000_000;
      $display("timeout with %0d result beats still due", outstanding);
      $display("Regression FAIL");
      $finish;
   end

   // receiver: random stall bursts, one long hold-off on request, none when calm
   initial begin
      bit stall_level;
      int stretch;
      rsp_stall <= 1'b0;
      @(posedge clock);
      forever begin
         if (hold_request && !hold_done) begin
            hold_done   = 1'b1;
            stall_level = 1'b1;
            stretch     = HOLD_CYCLES;
         end else if (calm) begin
            stall_level = 1'b0;
            stretch     = 1;
         end else if ($urandom_range(0, 3) == 0) begin
            stall_level = 1'b1;
            stretch     = $urandom_range(1, 6);
         end else begin
            stall_level = 1'b0;
            stretch     = $urandom_range(1, 24);
         end
         rsp_stall <= stall_level;
         repeat (stretch) @(posedge clock);
      end
   end

   function automatic blind_settings_type make_settings(int tu, int td, int lu, int ld,
                                                        int ov, int iv);
      blind_settings_type s;
      s.travel_up   = TRAVEL_W'(tu);
      s.travel_down = TRAVEL_W'(td);
      s.lag_up      = OFFSET_W'(lu);
      s.lag_down    = OFFSET_W'(ld);
      s.overrun     = OVERRUN_W'(ov);
      s.interval    = INTERVAL_W'(iv);
      return s;
   endfunction

   // one register write per clock, enable lowered once after the last one
   task automatic write_csr(logic [CSR_IDX_W-1:0] idx, logic [CSR_DATA_W-1:0] data);
      csr_write_en   <= 1'b1;
      csr_index      <= idx;
      csr_write_data <= data;
      @(posedge clock);
   endtask

   task automatic load_settings(blind_settings_type s);
      write_csr(CSR_TRAVEL_UP,   CSR_DATA_W'(s.travel_up));
      write_csr(CSR_TRAVEL_DOWN, CSR_DATA_W'(s.travel_down));
      write_csr(CSR_OFFSET_UP,   CSR_DATA_W'(s.lag_up));
      write_csr(CSR_OFFSET_DOWN, CSR_DATA_W'(s.lag_down));
      write_csr(CSR_OVERRUN,     CSR_DATA_W'(s.overrun));
      write_csr(CSR_INTERVAL,    CSR_DATA_W'(s.interval));
      csr_write_en <= 1'b0;
      active = s;
      settings_used++;
   endtask

   // offer one command beat, hold it until taken, then maybe idle a while;
   // valid stays high straight into the next beat when there is no gap
   task automatic send_beat(opcode_type op, logic [TIME_W-1:0] stamp,
                            logic [POS_PORT_W-1:0] target);
      int gap;
      gap = (!calm && $urandom_range(0, 3) == 0) ? $urandom_range(1, 6) : 0;
      req_valid           <= 1'b1;
      req_opcode          <= op;
      req_time_ms         <= stamp;
      req_target_position <= target;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      beats_sent++;
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   // all results back, block idle again
   task automatic wait_drained();
      req_valid <= 1'b0;
      @(posedge clock);
      while (outstanding != 0) @(posedge clock);
   endtask

   // mostly ticks with time steps scaled to the travel time, so that moves
   // run to their goal; commands and odd time jumps in between
   task automatic run_random(int count);
      int         span, pick;
      opcode_type op;
      logic [POS_PORT_W-1:0] target;
      span = int'(active.travel_up > active.travel_down ? active.travel_up
                                                        : active.travel_down)
           + int'(active.lag_up > active.lag_down ? active.lag_up : active.lag_down)
           + int'(active.overrun);
      now_ms = $urandom;
      repeat (count) begin
         pick = $urandom_range(0, 99);
         if (pick < 62)
            op = OP_TICK;
         else if (pick < 80)
            op = OP_SET;
         else if (pick < 90)
            op = OP_TOGGLE;
         else
            op = OP_STOP;
         case ($urandom_range(0, 5))
            0:       target = '0;
            1:       target = '1;
            default: target = POS_PORT_W'($urandom_range(0, 65535));
         endcase
         pick = $urandom_range(0, 39);
         if (pick == 0)
            now_ms = now_ms + $urandom;
         else if (pick > 3)
            now_ms = now_ms + $urandom_range(1, span / 5 + 2);
         send_beat(op, now_ms, target);
      end
   endtask

   task automatic run_phase(blind_settings_type s, int count);
      load_settings(s);
      run_random(count);
      wait_drained();
   endtask

   function automatic blind_settings_type random_settings();
      return make_settings($urandom_range(1, 3000), $urandom_range(1, 3000),
                           $urandom_range(0, 400), $urandom_range(0, 400),
                           ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 500),
                           $urandom_range(1, 300));
   endfunction

   initial begin
      logic [TIME_W-1:0] t0;
      reset               <= 1'b1;
      csr_write_en        <= 1'b0;
      csr_index           <= CSR_TRAVEL_UP;
      csr_write_data      <= '0;
      req_valid           <= 1'b0;
      req_opcode          <= OP_TICK;
      req_time_ms         <= '0;
      req_target_position <= '0;
      calm          = 1'b0;
      hold_request  = 1'b0;
      beats_sent    = 0;
      settings_used = 0;
      active        = make_settings(TRAVEL_RESET, TRAVEL_RESET, 0, 0, 0, INTERVAL_RESET);
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // reset settings: 30 s travel both ways, no offsets, no overrun
      send_beat(OP_TICK,   32'd0,    16'h0000);   // idle tick
      send_beat(OP_STOP,   32'd5,    16'hFFFF);   // stop while idle
      send_beat(OP_SET,    32'd10,   16'h0000);   // goal equals position
      send_beat(OP_SET,    32'd1000, 16'hFFFF);   // start opening
      send_beat(OP_TICK,   32'd1300, 16'h0000);   // inside report interval
      send_beat(OP_TICK,   32'd1501, 16'h0000);   // just past it
      send_beat(OP_SET,    32'd2000, 16'h8000);   // same direction, new goal
      send_beat(OP_TICK,   32'd16200, 16'h0000);  // overshoot, snap to goal
      send_beat(OP_TOGGLE, 32'd17000, 16'h0000);  // upper half: close
      send_beat(OP_TOGGLE, 32'd18000, 16'h0000);  // moving: stop
      send_beat(OP_TOGGLE, 32'd18500, 16'h0000);  // lower half: open
      send_beat(OP_SET,    32'd19000, 16'h1234);  // reverse
      send_beat(OP_SET,    32'd19100, 16'hFFFF);  // reverse again
      send_beat(OP_TICK,   32'h8000_0000, 16'h0000);  // delta saturates
      send_beat(OP_TICK,   32'hFFFF_FFF0, 16'h0000);
      send_beat(OP_SET,    32'hFFFF_FFF8, 16'h0000);  // close across the wrap
      send_beat(OP_TICK,   32'h0000_2000, 16'h0000);
      send_beat(OP_STOP,   32'h0000_3000, 16'h0000);
      wait_drained();

      // dead offsets and endstop overrun
      load_settings(make_settings(100, 150, 10, 20, 30, 7));
      t0 = 32'h7FFF_FFF0;
      send_beat(OP_SET,    t0,        16'hFFFF);
      send_beat(OP_TICK,   t0 + 5,    16'h0000);  // held in dead offset
      send_beat(OP_TICK,   t0 + 9,    16'h0000);
      send_beat(OP_TICK,   t0 + 40,   16'h0000);
      send_beat(OP_TICK,   t0 + 400,  16'h0000);  // fully open, overrun starts
      send_beat(OP_TICK,   t0 + 410,  16'h0000);  // relay still on
      send_beat(OP_TICK,   t0 + 430,  16'h0000);  // overrun over
      send_beat(OP_SET,    t0 + 500,  16'h0000);
      send_beat(OP_TICK,   t0 + 515,  16'h0000);
      send_beat(OP_TICK,   t0 + 2000, 16'h0000);  // closed, down overrun
      send_beat(OP_TOGGLE, t0 + 2005, 16'h0000);  // toggle during overrun stops
      send_beat(OP_TOGGLE, t0 + 2010, 16'h0000);
      send_beat(OP_STOP,   t0 + 2011, 16'h0000);
      wait_drained();

      // random traffic over the extremes, zero travel time and random settings
      run_phase(make_settings(1, 1, 0, 0, 0, 1), 75);
      run_phase(make_settings(600000, 600000, 60000, 60000, 600000, 60000), 75);
      run_phase(make_settings(0, 0, 3, 0, 5, 2), 75);
      hold_request = 1'b1;   // block fills up behind a stalled result
      run_phase(random_settings(), 75);
      run_phase(random_settings(), 75);
      calm = 1'b1;
      run_phase(random_settings(), 75);

      repeat (TAIL_CYCLES) @(posedge clock);
      $display("covered %0d command beats over %0d register settings, incl. time wrap,",
               beats_sent, settings_used);
      $display("endstop overrun, dead offsets and a %0d-cycle result hold-off",
               HOLD_CYCLES);
      if (mismatch_count == 0 && outstanding == 0)
         $display("Regression PASS");
      else
         $display("Regression FAIL");
      $finish;
   end

endmodule : tb_top
